@@ rtl/core/hht_pkg.sv @@
package hht_pkg;

  localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;
  localparam logic [31:0] HASH_INIT = 32'hDEAD_BEF3;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ABSENT   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

  // one mixing round of the hash: x ^= y; x -= rotl(y, r)
  function automatic logic [31:0] mix_step(input logic [31:0] x, input logic [31:0] y,
                                           input logic [4:0] r);
    logic [31:0] rot;
    rot = (y << r) | (y >> (6'd32 - {1'b0, r}));
    return (x ^ y) - rot;
  endfunction

endpackage

@@ rtl/core/hht_hash.sv @@
// Iterative hash: one mixing round per cycle over seven rounds.
module hht_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] seed,
  input  logic [31:0] key,
  output logic        done,
  output logic [31:0] hash
);

  logic [31:0] a, b, c;
  logic [2:0]  round;
  logic        run;
  logic [31:0] x, y, r_out;
  logic [4:0]  rot;
  logic [31:0] init;

  assign init = hht_pkg::HASH_INIT + seed;
  assign hash = c;

  // select operands of the shared mixer per round
  always_comb begin
    case (round)
      3'd0: begin x = c; y = b; rot = 5'd14; end
      3'd1: begin x = a; y = c; rot = 5'd11; end
      3'd2: begin x = b; y = a; rot = 5'd25; end
      3'd3: begin x = c; y = b; rot = 5'd16; end
      3'd4: begin x = a; y = c; rot = 5'd4;  end
      3'd5: begin x = b; y = a; rot = 5'd14; end
      default: begin x = c; y = b; rot = 5'd24; end
    endcase
    r_out = hht_pkg::mix_step(x, y, rot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      round <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        round <= '0;
      end else if (run) begin
        round <= round + 3'd1;
        if (round == 3'd6) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= init + key;
      b <= init;
      c <= init;
    end else if (run) begin
      case (round)
        3'd0, 3'd3, 3'd6: c <= r_out;
        3'd1, 3'd4:       a <= r_out;
        default:          b <= r_out;
      endcase
    end
  end

endmodule

@@ rtl/core/hopscotch_hash_table.sv @@
// Flow: the key is hashed, then each bucket read has an address state and a data state:
//   lookup/remove read up to HOP_RANGE buckets, the insert probe up to min(PROBE_LIMIT,
//   NUM_BUCKETS); a displacement step reads the owner bitmap, scans owner/entry pairs and moves;
//   placing reads the home bitmap and stores. Reserved key or unknown command go straight to S_DONE.
// Throughput: one request at a time; busy falls in the cycle that carries the result strobe.
// Reset: a clearing pass over every bucket empties the tables (busy high); no receiver stall.
module hopscotch_hash_table #(
  parameter int NUM_BUCKETS = 1024,
  parameter int HOP_RANGE   = 32,
  parameter int PROBE_LIMIT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] key,
  input  logic [31:0] value,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  bucket_index
);

  localparam int AW    = $clog2(NUM_BUCKETS);
  localparam int LIMIT = (PROBE_LIMIT < NUM_BUCKETS) ? PROBE_LIMIT : NUM_BUCKETS;
  localparam int DW    = $clog2(LIMIT + 1);
  localparam int HW    = $clog2(HOP_RANGE);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_FIND   = 4'd3;
  localparam logic [3:0] S_FINDW  = 4'd4;
  localparam logic [3:0] S_PROBE  = 4'd5;
  localparam logic [3:0] S_PRBW   = 4'd6;
  localparam logic [3:0] S_OWN    = 4'd7;
  localparam logic [3:0] S_OWNW   = 4'd8;
  localparam logic [3:0] S_SRC    = 4'd9;
  localparam logic [3:0] S_SRCW   = 4'd10;
  localparam logic [3:0] S_MOVE   = 4'd11;
  localparam logic [3:0] S_PLACE  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;
  localparam logic [3:0] S_PLACEW = 4'd14;

  // memories
  logic [31:0] keys_mem [NUM_BUCKETS];
  logic [31:0] vals_mem [NUM_BUCKETS];
  logic [HOP_RANGE-1:0] hop_mem [NUM_BUCKETS];

  logic [3:0]  state;
  logic [31:0] seed;
  logic [1:0]  r_cmd;
  logic [31:0] r_key, r_val;
  logic [AW-1:0] home, clr;
  logic [DW-1:0] d;        // probe / free offset from home
  logic [HW:0]   k;        // neighborhood index
  logic [DW-1:0] i_off;    // owner offset
  logic [HOP_RANGE-1:0] own_bm;
  logic [31:0] mv_val;

  // single read port per memory, registered data
  logic [AW-1:0] raddr;
  logic [31:0]   rd_key, rd_val;
  logic [HOP_RANGE-1:0] rd_hop;

  logic hash_go, hash_done;
  logic [31:0] hash;

  hht_hash u_hash (
    .clk(clk), .rst(rst), .start(hash_go), .seed(seed), .key(key),
    .done(hash_done), .hash(hash)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    rd_key <= keys_mem[raddr];
    rd_val <= vals_mem[raddr];
    rd_hop <= hop_mem[raddr];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) seed <= '0;
    else if (cfg_we) seed <= cfg_wdata;
  end

  logic [AW-1:0] d_addr, own_addr, src_addr;
  assign d_addr   = home + AW'(d);
  assign own_addr = home + AW'(i_off);
  assign src_addr = home + AW'(i_off) + AW'(k);

  // read address: set in the state before the one that uses the registered data
  always_comb begin
    case (state)
      S_FIND, S_FINDW: raddr = home + AW'(k);
      S_PROBE, S_PRBW: raddr = d_addr;
      S_OWN, S_OWNW:   raddr = own_addr;
      S_SRC, S_SRCW:   raddr = src_addr;
      default:         raddr = home;
    endcase
  end

  logic [DW:0] ik;
  assign ik = {1'b0, i_off} + (DW+1)'(k);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          keys_mem[clr] <= hht_pkg::EMPTY_KEY;
          hop_mem[clr]  <= '0;
          clr <= clr + 1'b1;
          if (clr == AW'(NUM_BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            r_cmd <= cmd; r_key <= key; r_val <= value;
            if (key == hht_pkg::EMPTY_KEY) begin
              status <= hht_pkg::ST_RESERVED; state <= S_DONE;
            end else if (cmd != hht_pkg::CMD_INSERT && cmd != hht_pkg::CMD_LOOKUP &&
                         cmd != hht_pkg::CMD_REMOVE) begin
              status <= hht_pkg::ST_ABSENT; state <= S_DONE;
            end else state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            home <= hash[AW-1:0];
            k <= '0; d <= '0;
            state <= (r_cmd == hht_pkg::CMD_INSERT) ? S_PROBE : S_FIND;
          end
        end
        // neighborhood search: read bitmap of home then key per slot
        S_FIND: state <= S_FINDW;
        S_FINDW: begin
          if (k == '0) own_bm <= rd_hop;
          if (k != '0 || rd_hop[0]) begin
            if (((k == '0) ? rd_hop[0] : own_bm[k[HW-1:0]]) && rd_key == r_key) begin
              status <= hht_pkg::ST_OK;
              bucket_index <= 10'(home + AW'(k));
              if (r_cmd == hht_pkg::CMD_REMOVE) begin
                keys_mem[home + AW'(k)] <= hht_pkg::EMPTY_KEY;
                vals_mem[home + AW'(k)] <= '1;
                hop_mem[home] <= ((k == '0) ? rd_hop : own_bm) &
                                 ~(HOP_RANGE'(1) << k[HW-1:0]);
              end
              state <= S_DONE;
            end else if (k == (HW+1)'(HOP_RANGE - 1)) begin
              status <= hht_pkg::ST_ABSENT; state <= S_DONE;
            end else begin
              k <= k + 1'b1; state <= S_FIND;
            end
          end else if (k == (HW+1)'(HOP_RANGE - 1)) begin
            status <= hht_pkg::ST_ABSENT; state <= S_DONE;
          end else begin
            k <= k + 1'b1; state <= S_FIND;
          end
        end
        // linear probe for an empty bucket
        S_PROBE: state <= S_PRBW;
        S_PRBW: begin
          if (rd_key == hht_pkg::EMPTY_KEY) begin
            if (d < DW'(HOP_RANGE)) state <= S_PLACE;
            else begin
              i_off <= d - DW'(HOP_RANGE - 1); state <= S_OWN;
            end
          end else if (d == DW'(LIMIT - 1)) begin
            status <= hht_pkg::ST_FULL; state <= S_DONE;
          end else begin
            d <= d + 1'b1; state <= S_PROBE;
          end
        end
        // displacement: owner bitmap, then candidate entries
        S_OWN: state <= S_OWNW;
        S_OWNW: begin
          own_bm <= rd_hop; k <= '0; state <= S_SRC;
        end
        S_SRC: state <= S_SRCW;
        S_SRCW: begin
          if (own_bm[k[HW-1:0]] && rd_key != hht_pkg::EMPTY_KEY) begin
            mv_val <= rd_val; state <= S_MOVE;
          end else if (ik + 1'b1 < (DW+1)'(d)) begin
            k <= k + 1'b1; state <= S_SRC;
          end else if (i_off + 1'b1 < d) begin
            i_off <= i_off + 1'b1; state <= S_OWN;
          end else begin
            status <= hht_pkg::ST_FULL; state <= S_DONE;
          end
        end
        S_MOVE: begin
          keys_mem[d_addr] <= rd_key;
          vals_mem[d_addr] <= mv_val;
          keys_mem[src_addr] <= hht_pkg::EMPTY_KEY;
          hop_mem[own_addr] <= (own_bm & ~(HOP_RANGE'(1) << k[HW-1:0])) |
                               (HOP_RANGE'(1) << HW'(d - i_off));
          d <= DW'(ik);
          if (DW'(ik) < DW'(HOP_RANGE)) state <= S_PLACE;
          else begin
            i_off <= DW'(ik) - DW'(HOP_RANGE - 1); state <= S_OWN;
          end
        end
        // place: read the home bitmap (raddr = home), then store the entry
        S_PLACE: state <= S_PLACEW;
        S_PLACEW: begin
          keys_mem[d_addr] <= r_key;
          vals_mem[d_addr] <= r_val;
          hop_mem[home] <= rd_hop | (HOP_RANGE'(1) << HW'(d));
          bucket_index <= 10'(d_addr);
          status <= hht_pkg::ST_OK;
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          if (status != hht_pkg::ST_OK) bucket_index <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign hash_go = (state == S_IDLE) && start && key != hht_pkg::EMPTY_KEY;

  // checks
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");
  a_ok_only_index: assert property (@(posedge clk) disable iff (rst)
    done && status != hht_pkg::ST_OK |-> bucket_index == '0)
    else $error("index set on failure");

endmodule
